// ===== rtl/keyed_event_stat_accumulator_assert.svh =====
// Assertion macros shared by the keyed event statistics accumulator checker.
// Each macro expects a signal named clock, and the first two also one named reset, in the scope of its use.
`ifndef KEYED_EVENT_STAT_ACCUMULATOR_ASSERT_SVH
`define KEYED_EVENT_STAT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define KESA_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed event stat accumulator: assertion failed");

// Next-cycle implication, ignored while reset is high.
`define KESA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed event stat accumulator: assertion failed");

// Next-cycle implication that also holds across reset.
`define KESA_ASSERT_RESET(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("keyed event stat accumulator: reset assertion failed");

`endif

// ===== rtl/kesa_pkg.sv =====
// Package for the keyed event statistics accumulator: types, constants and
// the error classification function. Depends on nothing.
package kesa_pkg;

   localparam int DefaultCapacity = 64;

   localparam logic [31:0] ERR32_LIMIT = 32'hFFFF_F000;

   typedef enum logic [1:0] {
      FUNC_RECORD = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [11:0] key;
      logic        mode32;
      logic [31:0] calls;
      logic [47:0] time_sum;
      logic [31:0] errors;
   } entry_type;

   typedef struct packed {
      logic [5:0]  hit_slot;
      logic        is_new;
      logic        dropped;
      logic        is_error;
      logic        entry_valid;
      entry_type   entry;
      logic [6:0]  entry_count;
   } rsp_type;

   // An event is an error in 64-bit mode when the 64-bit value is negative,
   // or in 32-bit mode when the low word lies above the error limit.
   function automatic logic kesa_is_error(input logic mode32,
                                          input logic signed [63:0] rv);
      if (mode32) begin
         return rv[31:0] > ERR32_LIMIT;
      end
      return rv[63];
   endfunction

   // Adds one event to a stored entry, each counter saturating.
   function automatic entry_type kesa_update(input entry_type cur,
                                             input logic [31:0] ticks,
                                             input logic err);
      entry_type   nxt;
      logic [48:0] tsum;
      nxt = cur;
      if (!(&cur.calls)) begin
         nxt.calls = cur.calls + 32'd1;
      end
      tsum = {1'b0, cur.time_sum} + {17'd0, ticks};
      nxt.time_sum = tsum[48] ? {48{1'b1}} : tsum[47:0];
      if (err && !(&cur.errors)) begin
         nxt.errors = cur.errors + 32'd1;
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/keyed_event_stat_accumulator.sv =====
// Top level of the keyed event statistics accumulator: the entry memory,
// the search sequencer and the response register. Depends on kesa_pkg.
//
// The block keeps a table of up to CAPACITY entries, one per event
// identifier, in a single synchronous memory with registered read data.
// A record transaction scans the used entries one per cycle, with the
// memory read for one slot overlapping the key compare of the previous
// one. On a hit the entry is updated in place (calls, time and errors all
// saturate); on a miss a new entry is appended, or the event is dropped
// and flagged when the table is full. A record ends its scan at the first
// hit, or after the last entry in use when it misses; on an empty table
// it misses at once. A read of a live slot passes through the read state
// to fetch the entry, while a read of an unused slot, a clear or an unused
// function code goes straight to the response state. The block works on
// one transaction at a time: req_stall is high from acceptance until the
// result has moved into the response register, which then holds it for as
// long as the consumer stalls while the next request is already taken.
// The memory needs no clearing pass after reset, since only entries below
// the fill count are ever read and every such entry has been written.
module keyed_event_stat_accumulator #(
   parameter int CAPACITY = kesa_pkg::DefaultCapacity
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [11:0]        req_event_id,
   input  logic               req_mode32,
   input  logic [31:0]        req_elapsed_ticks,
   input  logic signed [63:0] req_return_value,
   input  logic [5:0]         req_read_slot,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_hit_slot,
   output logic               rsp_is_new,
   output logic               rsp_dropped,
   output logic               rsp_is_error,
   output logic               rsp_entry_valid,
   output logic [11:0]        rsp_entry_key,
   output logic               rsp_entry_mode32,
   output logic [31:0]        rsp_entry_calls,
   output logic [47:0]        rsp_entry_time,
   output logic [31:0]        rsp_entry_errors,
   output logic [6:0]         rsp_entry_count
);
   import kesa_pkg::*;

   // Slot index width and the width of a count that can reach CAPACITY.
   localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] CAP_L = CW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_READ,
      ST_RESP
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     used_ff;
   logic [CW-1:0]     scan_ff;
   logic [SW-1:0]     cmp_idx_ff;
   logic              vld_ff;
   logic              rsp_valid_ff;
   rsp_type           res_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   // Latched fields of the transaction being worked on.
   logic [11:0]       id_ff;
   logic              mode_ff;
   logic [31:0]       ticks_ff;
   logic              err_ff;

   // Entry memory and its registered read data.
   entry_type         mem [CAPACITY];
   entry_type         mem_rd_ff;

   logic              issue;
   logic              hit;
   logic              miss;
   logic              room;
   logic              wr_en;
   logic [SW-1:0]     wr_addr;
   entry_type         wr_data;
   logic [SW-1:0]     rd_addr;
   entry_type         upd_entry;
   entry_type         new_entry;
   logic              slot_ok;
   logic              rsp_load;

   // A read is issued each scan cycle while slots remain; the data of the
   // slot issued in the previous cycle is compared in this one.
   assign issue = (state_ff == ST_SEARCH) && (scan_ff < used_ff);
   assign hit   = (state_ff == ST_SEARCH) && vld_ff && (mem_rd_ff.key == id_ff);
   assign miss  = (state_ff == ST_SEARCH) && !vld_ff && (scan_ff >= used_ff);
   assign room  = used_ff < CAP_L;

   assign upd_entry = kesa_update(mem_rd_ff, ticks_ff, err_ff);

   always_comb begin
      new_entry          = '0;
      new_entry.key      = id_ff;
      new_entry.mode32   = mode_ff;
      new_entry.calls    = 32'd1;
      new_entry.time_sum = {16'd0, ticks_ff};
      new_entry.errors   = {31'd0, err_ff};
   end

   // The finished result moves into the response register once that
   // register is empty or being emptied at this edge.
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in             = res_ff;
      rsp_in.entry_count = 7'(used_ff);
   end

   assign wr_en   = hit || (miss && room);
   assign wr_addr = hit ? cmp_idx_ff : used_ff[SW-1:0];
   assign wr_data = hit ? upd_entry : new_entry;
   assign rd_addr = (state_ff == ST_IDLE) ? SW'(req_read_slot) : scan_ff[SW-1:0];
   assign slot_ok = CMPW'(req_read_slot) < CMPW'(used_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         vld_ff     <= issue;
         cmp_idx_ff <= scan_ff[SW-1:0];
         if (issue) begin
            scan_ff <= scan_ff + CW'(1);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  id_ff    <= req_event_id;
                  mode_ff  <= req_mode32;
                  ticks_ff <= req_elapsed_ticks;
                  err_ff   <= kesa_is_error(req_mode32, req_return_value);
                  res_ff   <= '0;
                  unique case (func_type'(req_func))
                     FUNC_RECORD: begin
                        scan_ff  <= '0;
                        state_ff <= ST_SEARCH;
                     end
                     FUNC_READ: begin
                        state_ff <= slot_ok ? ST_READ : ST_RESP;
                     end
                     FUNC_CLEAR: begin
                        used_ff  <= '0;
                        state_ff <= ST_RESP;
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end

            ST_SEARCH: begin
               res_ff.is_error <= err_ff;
               if (hit) begin
                  res_ff.hit_slot    <= 6'(cmp_idx_ff);
                  res_ff.entry_valid <= 1'b1;
                  res_ff.entry       <= upd_entry;
                  state_ff           <= ST_RESP;
               end else if (miss) begin
                  if (room) begin
                     res_ff.hit_slot    <= 6'(used_ff);
                     res_ff.is_new      <= 1'b1;
                     res_ff.entry_valid <= 1'b1;
                     res_ff.entry       <= new_entry;
                     used_ff            <= used_ff + CW'(1);
                  end else begin
                     res_ff.dropped <= 1'b1;
                  end
                  state_ff <= ST_RESP;
               end
            end

            ST_READ: begin
               res_ff.entry_valid <= 1'b1;
               res_ff.entry       <= mem_rd_ff;
               state_ff           <= ST_RESP;
            end

            ST_RESP: begin
               if (rsp_load) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_slot     = rsp_ff.hit_slot;
   assign rsp_is_new       = rsp_ff.is_new;
   assign rsp_dropped      = rsp_ff.dropped;
   assign rsp_is_error     = rsp_ff.is_error;
   assign rsp_entry_valid  = rsp_ff.entry_valid;
   assign rsp_entry_key    = rsp_ff.entry.key;
   assign rsp_entry_mode32 = rsp_ff.entry.mode32;
   assign rsp_entry_calls  = rsp_ff.entry.calls;
   assign rsp_entry_time   = rsp_ff.entry.time_sum;
   assign rsp_entry_errors = rsp_ff.entry.errors;
   assign rsp_entry_count  = rsp_ff.entry_count;

endmodule

// ===== rtl/kesa_check.sv =====
// Port-level checker for the keyed event statistics accumulator, bound to
// the top level. Depends on keyed_event_stat_accumulator_assert.svh.
`include "keyed_event_stat_accumulator_assert.svh"

module kesa_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [5:0]         rsp_hit_slot,
   input logic               rsp_is_new,
   input logic               rsp_dropped,
   input logic               rsp_is_error,
   input logic               rsp_entry_valid,
   input logic [31:0]        rsp_entry_calls,
   input logic [31:0]        rsp_entry_errors,
   input logic [6:0]         rsp_entry_count
);

   // After reset the block is empty and ready for a transaction.
   `KESA_ASSERT_RESET(a_reset_idle, reset, !rsp_valid && !req_stall)

   // One transaction at a time: an accepted request blocks the next.
   `KESA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // A stalled response stays offered, with its entry count and hit slot unchanged.
   `KESA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_entry_count) && $stable(rsp_hit_slot))

   // A dropped event creates nothing and shows no entry.
   `KESA_ASSERT_IMPL(a_drop_shape, rsp_valid && rsp_dropped,
                     !rsp_is_new && !rsp_entry_valid && rsp_hit_slot == 6'd0)

   // A freshly created entry holds exactly this one event.
   `KESA_ASSERT_IMPL(a_new_shape, rsp_valid && rsp_is_new,
                     rsp_entry_valid && rsp_entry_calls == 32'd1 &&
                     rsp_entry_errors == 32'(rsp_is_error))

endmodule

bind keyed_event_stat_accumulator kesa_check u_kesa_check (.*);
